// File: rtl/core/clock_synth_divider_search_assert.svh
// Assertion macros for the synthesiser divider search RTL
`ifndef CLOCK_SYNTH_DIVIDER_SEARCH_ASSERT_SVH
`define CLOCK_SYNTH_DIVIDER_SEARCH_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CSDS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csds check failed");

// next-cycle implication, checked out of reset
`define CSDS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csds check failed");

`endif

// File: rtl/core/csds_pkg.sv
// Types, constants and divider tables of the synthesiser divider search
package csds_pkg;

    localparam int MUL_W  = 12;           // multiplier digit count (N1*HS)
    localparam int MCD_W  = 32;           // multiplicand width
    localparam int PROD_W = MUL_W + MCD_W;
    localparam int FRAC_W = 44;           // numerator scaled by 2^44
    localparam int DEN_W  = 48;
    localparam int DIV_STEPS = PROD_W + FRAC_W;
    localparam int RFREQ_W = 38;
    localparam int HS_LAST = 5;

    localparam logic [7:0] REG_HS_N1   = 8'd7;
    localparam logic [7:0] REG_N1_RF   = 8'd8;
    localparam logic [7:0] REG_RF_1    = 8'd9;
    localparam logic [7:0] REG_RF_2    = 8'd10;
    localparam logic [7:0] REG_RF_3    = 8'd11;
    localparam logic [7:0] REG_RF_4    = 8'd12;
    localparam logic [7:0] REG_FREEZE  = 8'd137;
    localparam logic [7:0] REG_CTRL    = 8'd135;
    localparam logic [7:0] FREEZE_ON   = 8'h10;
    localparam logic [7:0] FREEZE_OFF  = 8'h00;
    localparam logic [7:0] NEW_FREQ    = 8'h40;

    localparam logic [1:0] CFG_DCO_MIN = 2'd0;
    localparam logic [1:0] CFG_DCO_MAX = 2'd1;
    localparam logic [1:0] CFG_STARTUP = 2'd2;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_stat_t;

    function automatic logic [3:0] hs_decode(input logic [2:0] code);
        case (code)
            3'd0:    hs_decode = 4'd4;
            3'd1:    hs_decode = 4'd5;
            3'd2:    hs_decode = 4'd6;
            3'd3:    hs_decode = 4'd7;
            3'd5:    hs_decode = 4'd9;
            3'd7:    hs_decode = 4'd11;
            default: hs_decode = 4'd0;
        endcase
    endfunction

    function automatic logic [2:0] hs_code_of(input logic [2:0] idx);
        case (idx)
            3'd0:    hs_code_of = 3'd0;
            3'd1:    hs_code_of = 3'd1;
            3'd2:    hs_code_of = 3'd2;
            3'd3:    hs_code_of = 3'd3;
            3'd4:    hs_code_of = 3'd5;
            default: hs_code_of = 3'd7;
        endcase
    endfunction

endpackage

// File: rtl/core/csds_serial_div.sv
// Bit-serial restoring divider: floor(num * 2^44 / den) with overflow flag
module csds_serial_div
    import csds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [PROD_W-1:0]   num,
    input  logic [DEN_W-1:0]    den,
    output div_stat_t           stat,
    output logic [DEN_W-1:0]    quo,
    output logic [DEN_W-1:0]    rem
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                ovf_reg, ovf_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PROD_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [DEN_W-1:0]    quo_reg, quo_next;
    logic [DEN_W:0]      trial;
    logic                qbit;

    always_comb
    begin
        trial     = {rem_reg, num_reg[PROD_W-1]};
        qbit      = (trial >= {1'b0, den});
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            ovf_next  = 1'b0;
            cnt_next  = '0;
            num_next  = num;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[PROD_W-2:0], 1'b0};
            rem_next = qbit ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
            // a quotient bit pushed out of the top means it passed 2^48-1
            ovf_next = ovf_reg | quo_reg[DEN_W-1];
            quo_next = {quo_reg[DEN_W-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg <= ovf_next;
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign quo       = quo_reg;
    assign rem       = rem_reg;

endmodule

// File: rtl/core/clock_synth_divider_search.sv
// Top level: readback decoding, crystal derivation and divider search
//
// Input stream (s_*): one request per transfer. s_tuser = 0 carries a
// readback byte of device registers 7 to 12; s_tuser = 1 asks for a new
// output frequency. Output stream (m_*): register writes (m_tuser = 0) or a
// crystal frequency report (m_tuser = 1); m_tlast marks the last result of
// a request. Config port: cfg_we with cfg_addr 0/1/2 writes the DCO lower
// limit, DCO upper limit and startup frequency.
// Flow: readback bytes of registers 7 to 11 only update the code and RFREQ
// registers. Register 12 runs a bit-serial multiply (startup * N1 * HS) and
// a bit-serial divide by RFREQ to the report. A set request walks 6 x
// (N1_LIMIT/2 + 1) candidates, each through the same multiplier and, when
// its DCO frequency is in the limits, the divider; then 9 writes if one fits.
// One request is in flight at a time; the output register lets the next
// request be taken while the final result waits. A stalled m_tready holds
// the search at its emit step. Reset clears the codes, RFREQ, crystal
// frequency and limits to their defaults; no result is pending after reset.
module clock_synth_divider_search
    import csds_pkg::*;
#(
    parameter int N1_LIMIT = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // reg_addr[7:0], reg_value[15:8], target_freq_hz[47:16]
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // write_addr[7:0], write_data[15:8], crystal_freq[63:16]
    output logic        m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [32:0] cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CAND = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_ADV  = 3'd5;
    localparam logic [2:0] ST_RPT  = 3'd6;
    localparam logic [2:0] ST_EMIT = 3'd7;

    localparam int MCNT_W = $clog2(MUL_W);

    // control
    logic [2:0]          state_reg, state_next;
    logic                srch_reg, srch_next;      // 1: search, 0: crystal derivation
    logic                found_reg, found_next;
    logic [2:0]          h_reg, h_next;
    logic [7:0]          n_reg, n_next;
    logic [3:0]          emit_reg, emit_next;
    logic [MCNT_W-1:0]   mcnt_reg, mcnt_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // configuration and device state
    logic [32:0]         dco_min_reg, dco_max_reg;
    logic [31:0]         startup_reg;
    logic [2:0]          hs_reg, hs_next;
    logic [7:0]          n1_reg, n1_next;
    logic [RFREQ_W-1:0]  rfreq_reg, rfreq_next;
    logic [DEN_W-1:0]    xtal_reg, xtal_next;

    // datapath
    logic [31:0]         target_reg, target_next;
    logic [MCD_W-1:0]    mcand_reg, mcand_next;
    logic [MUL_W-1:0]    mpl_reg, mpl_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [DEN_W-1:0]    best_rem_reg, best_rem_next;
    logic [RFREQ_W-1:0]  best_rf_reg, best_rf_next;
    logic [2:0]          best_h_reg, best_h_next;
    logic [7:0]          best_n_reg, best_n_next;
    logic [63:0]         m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;
    logic                m_tlast_reg, m_tlast_next;

    logic                accept, out_free, div_start, dco_ok;
    logic [7:0]          in_addr, in_val, nn;
    logic [8:0]          n_plus;
    logic [RFREQ_W-1:0]  rf_shift;
    logic [DEN_W-1:0]    div_den, div_quo, div_rem;
    div_stat_t           div_stat;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;
    assign in_addr  = s_tdata[7:0];
    assign in_val   = s_tdata[15:8];
    assign rf_shift = {rfreq_reg[RFREQ_W-9:0], in_val};
    assign nn       = (n_reg == 8'd0) ? 8'd1 : n_reg;
    assign n_plus   = {1'b0, n_reg} + 9'd2;
    assign dco_ok   = (acc_reg >= PROD_W'(dco_min_reg)) && (acc_reg <= PROD_W'(dco_max_reg))
                      && (acc_reg != '0);
    assign div_den  = srch_reg ? xtal_reg : DEN_W'(rfreq_reg);
    assign div_start = ((state_reg == ST_MUL) && (mcnt_reg == MCNT_W'(MUL_W - 1)) && !srch_reg)
                       || ((state_reg == ST_CHK) && dco_ok);

    csds_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_next),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    always_comb
    begin
        state_next    = state_reg;
        srch_next     = srch_reg;
        found_next    = found_reg;
        h_next        = h_reg;
        n_next        = n_reg;
        emit_next     = emit_reg;
        mcnt_next     = mcnt_reg;
        hs_next       = hs_reg;
        n1_next       = n1_reg;
        rfreq_next    = rfreq_reg;
        xtal_next     = xtal_reg;
        target_next   = target_reg;
        mcand_next    = mcand_reg;
        mpl_next      = mpl_reg;
        acc_next      = acc_reg;
        best_rem_next = best_rem_reg;
        best_rf_next  = best_rf_reg;
        best_h_next   = best_h_reg;
        best_n_next   = best_n_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !s_tuser)
                begin
                    case (in_addr)
                        REG_HS_N1:
                        begin
                            hs_next = in_val[7:5];
                            n1_next = {1'b0, in_val[4:0], 2'b00};
                        end
                        REG_N1_RF:
                        begin
                            n1_next    = n1_reg | {6'd0, in_val[7:6]};
                            rfreq_next = RFREQ_W'(in_val[5:0]);
                        end
                        REG_RF_1, REG_RF_2, REG_RF_3:
                            rfreq_next = rf_shift;
                        REG_RF_4:
                        begin
                            rfreq_next = rf_shift;
                            if (rf_shift != '0)
                            begin
                                // startup * N1 * HS, then the divide by RFREQ
                                srch_next  = 1'b0;
                                mcand_next = startup_reg;
                                mpl_next   = MUL_W'({1'b0, n1_reg} + 9'd1)
                                             * MUL_W'(hs_decode(hs_reg));
                                acc_next   = '0;
                                mcnt_next  = '0;
                                state_next = ST_MUL;
                            end
                        end
                        default:
                            ;
                    endcase
                end
                else if (accept && s_tuser && (xtal_reg != '0))
                begin
                    srch_next   = 1'b1;
                    found_next  = 1'b0;
                    h_next      = '0;
                    n_next      = '0;
                    target_next = s_tdata[47:16];
                    state_next  = ST_CAND;
                end
            end
            ST_CAND:
            begin
                mcand_next = target_reg;
                mpl_next   = MUL_W'(nn) * MUL_W'(hs_decode(hs_code_of(h_reg)));
                acc_next   = '0;
                mcnt_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // MSB-first shift-and-add, one multiplier bit per cycle
                acc_next  = {acc_reg[PROD_W-2:0], 1'b0}
                            + (mpl_reg[MUL_W-1] ? PROD_W'(mcand_reg) : '0);
                mpl_next  = {mpl_reg[MUL_W-2:0], 1'b0};
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == MCNT_W'(MUL_W - 1))
                    state_next = srch_reg ? ST_CHK : ST_DIV;
            end
            ST_CHK:
                state_next = dco_ok ? ST_DIV : ST_ADV;
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    if (!srch_reg)
                    begin
                        xtal_next  = div_stat.ovf ? '1 : div_quo;
                        state_next = ST_RPT;
                    end
                    else
                    begin
                        // later candidate wins on an equal remainder
                        if (!div_stat.ovf && (div_quo[DEN_W-1:RFREQ_W] == '0)
                            && (!found_reg || (div_rem <= best_rem_reg)))
                        begin
                            found_next    = 1'b1;
                            best_rem_next = div_rem;
                            best_rf_next  = div_quo[RFREQ_W-1:0];
                            best_h_next   = hs_code_of(h_reg);
                            best_n_next   = nn - 8'd1;
                        end
                        state_next = ST_ADV;
                    end
                end
            end
            ST_ADV:
            begin
                if (n_plus > 9'(N1_LIMIT))
                begin
                    n_next = '0;
                    if (h_reg == 3'(HS_LAST))
                    begin
                        emit_next  = '0;
                        state_next = found_reg ? ST_EMIT : ST_IDLE;
                    end
                    else
                    begin
                        h_next     = h_reg + 3'd1;
                        state_next = ST_CAND;
                    end
                end
                else
                begin
                    n_next     = n_plus[7:0];
                    state_next = ST_CAND;
                end
            end
            ST_RPT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = 1'b1;
                    m_tdata_next  = {xtal_reg, 16'd0};
                    state_next    = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = 1'b0;
                    m_tlast_next  = (emit_reg == 4'd8);
                    case (emit_reg)
                        4'd0: m_tdata_next = {48'd0, FREEZE_ON, REG_FREEZE};
                        4'd1: m_tdata_next = {48'd0, best_h_reg, best_n_reg[6:2], REG_HS_N1};
                        4'd2: m_tdata_next = {48'd0, best_n_reg[1:0], best_rf_reg[37:32],
                                              REG_N1_RF};
                        4'd3: m_tdata_next = {48'd0, best_rf_reg[31:24], REG_RF_1};
                        4'd4: m_tdata_next = {48'd0, best_rf_reg[23:16], REG_RF_2};
                        4'd5: m_tdata_next = {48'd0, best_rf_reg[15:8], REG_RF_3};
                        4'd6: m_tdata_next = {48'd0, best_rf_reg[7:0], REG_RF_4};
                        4'd7: m_tdata_next = {48'd0, FREEZE_OFF, REG_FREEZE};
                        default: m_tdata_next = {48'd0, NEW_FREQ, REG_CTRL};
                    endcase
                    emit_next = emit_reg + 4'd1;
                    if (emit_reg == 4'd8)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            srch_reg     <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            dco_min_reg  <= 33'd4850000000;
            dco_max_reg  <= 33'd5670000000;
            startup_reg  <= 32'd100000000;
            hs_reg       <= '0;
            n1_reg       <= '0;
            rfreq_reg    <= '0;
            xtal_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            srch_reg     <= srch_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
            hs_reg       <= hs_next;
            n1_reg       <= n1_next;
            rfreq_reg    <= rfreq_next;
            xtal_reg     <= xtal_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_DCO_MIN: dco_min_reg <= cfg_data;
                    CFG_DCO_MAX: dco_max_reg <= cfg_data;
                    CFG_STARTUP: startup_reg <= cfg_data[31:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg        <= h_next;
        n_reg        <= n_next;
        emit_reg     <= emit_next;
        mcnt_reg     <= mcnt_next;
        target_reg   <= target_next;
        mcand_reg    <= mcand_next;
        mpl_reg      <= mpl_next;
        acc_reg      <= acc_next;
        best_rem_reg <= best_rem_next;
        best_rf_reg  <= best_rf_next;
        best_h_reg   <= best_h_next;
        best_n_reg   <= best_n_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`include "clock_synth_divider_search_assert.svh"

    // the divider is never started against a zero divisor
    `CSDS_ASSERT_IMP(a_div_den_nonzero, div_start, div_den != '0)
    // writes are only emitted once a candidate has qualified
    `CSDS_ASSERT_IMP(a_emit_found, state_reg == ST_EMIT, found_reg)
    // a crystal report is always the single, final result of its request
    `CSDS_ASSERT_IMP(a_report_last, m_tvalid && m_tuser, m_tlast)
    // leaving the emit step means the new-frequency write went out
    `CSDS_ASSERT_NXT(a_emit_end, (state_reg == ST_EMIT) && out_free && (emit_reg == 4'd8),
                     m_tvalid && m_tlast && (state_reg == ST_IDLE))

endmodule
